FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file coi_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define COI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define COI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/coi_pkg.sv
// Types and constants of the closest overlapping interval search.
`default_nettype none

package coi_pkg;

    localparam logic [31:0] NO_MATCH = 32'd999999999;
    localparam logic        ACT_QUERY = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_ctrl_t;

    typedef struct packed {
        logic [30:0] start_pos;
        logic [30:0] end_pos;
    } entry_t;

endpackage

`default_nettype wire

FILE: rtl/coi_if.sv
// Request and response channel interfaces of the interval search.
`default_nettype none

interface coi_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [11:0] entry_index;
    logic [30:0] entry_start;
    logic [30:0] entry_end;
    logic [12:0] scan_begin;
    logic [12:0] scan_end;
    logic [30:0] span_first;
    logic [30:0] span_last;

    modport source (
        output valid, action, entry_index, entry_start, entry_end,
               scan_begin, scan_end, span_first, span_last,
        input  ready
    );
    modport sink (
        input  valid, action, entry_index, entry_start, entry_end,
               scan_begin, scan_end, span_first, span_last,
        output ready
    );
endinterface

interface coi_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic        [11:0] best_index;
    logic        [31:0] best_distance;
    logic signed [31:0] start_offset;
    logic signed [31:0] end_offset;

    modport source (
        output valid, found, best_index, best_distance, start_offset, end_offset,
        input  ready
    );
    modport sink (
        input  valid, found, best_index, best_distance, start_offset, end_offset,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/coi_alu.sv
// Shared 32-bit add/subtract unit used by the scan sequencer.
`default_nettype none

module coi_alu
    import coi_pkg::*;
(
    input  alu_ctrl_t   ctrl,
    output logic [31:0] y
);

    always_comb
    begin
        unique case (ctrl.op)
            ALU_ADD: y = ctrl.a + ctrl.b;
            ALU_SUB: y = ctrl.a - ctrl.b;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/coi_table.sv
// Interval table: one write port, one registered read port.
`default_nettype none

module coi_table
    import coi_pkg::*;
#(
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/closest_overlap_interval_search_core.sv
// Closest overlapping interval search: table, scan sequencer and result register.
//
// req carries two kinds of transaction. action 0 writes entry_start/entry_end
// into slot entry_index (slots at or beyond TABLE_DEPTH are dropped) and
// gives no response. action 1 scans slots [scan_begin, scan_end) (scan_end
// clamped to TABLE_DEPTH) against span_first/span_last and gives one rsp
// transaction.
// A query walks the table one slot at a time through the shared adder:
// a slot that does not overlap passes FETCH and ABS_S; an overlapping slot
// passes FETCH, ABS_S, ABS_E, SUM and UPDATE, or stops the scan after ABS_E;
// the result is then finished in NEG_S, NEG_E and RESULT before rsp.valid.
// req.ready is high only while the sequencer is idle; a finished response
// sits in the output register, so a new transaction is taken while it waits.
// A query that finishes while rsp is still stalled holds until rsp.ready.
// Reset clears the sequencer and the response valid; the table is not
// cleared and a slot must be written before a query reads it.
`default_nettype none

module closest_overlap_interval_search_core
    import coi_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 4096
)
(
    input  logic      clk,
    input  logic      rst_n,
    coi_req_if.sink   req,
    coi_rsp_if.source rsp
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ABS_S,
        ST_ABS_E,
        ST_SUM,
        ST_UPDATE,
        ST_NEG_S,
        ST_NEG_E,
        ST_RESULT
    } state_t;

    state_t      state_reg, state_next;
    logic [12:0] idx_reg, idx_next;
    logic [12:0] hi_reg, hi_next;
    logic [30:0] first_reg, first_next;
    logic [30:0] last_reg, last_next;
    logic        found_reg, found_next;
    logic [11:0] best_idx_reg, best_idx_next;
    logic [31:0] best_dist_reg, best_dist_next;
    logic [31:0] best_ads_reg, best_ads_next;
    logic        best_sneg_reg, best_sneg_next;
    logic [31:0] best_ade_reg, best_ade_next;
    logic        best_eneg_reg, best_eneg_next;
    logic [31:0] ads_reg, ads_next;
    logic        sneg_reg, sneg_next;
    logic [31:0] ade_reg, ade_next;
    logic        eneg_reg, eneg_next;
    logic [31:0] dist_reg, dist_next;
    logic [31:0] soff_reg, soff_next;
    logic [31:0] eoff_reg, eoff_next;

    logic        rsp_valid_reg, rsp_valid_next;
    logic        rsp_found_reg, rsp_found_next;
    logic [11:0] rsp_idx_reg, rsp_idx_next;
    logic [31:0] rsp_dist_reg, rsp_dist_next;
    logic [31:0] rsp_soff_reg, rsp_soff_next;
    logic [31:0] rsp_eoff_reg, rsp_eoff_next;

    alu_ctrl_t   alu_ctrl;
    logic [31:0] alu_y;

    logic          tbl_we;
    logic [31:0]   wslot_w;
    logic [31:0]   rslot_w;
    logic [AW-1:0] tbl_waddr;
    logic [AW-1:0] tbl_raddr;
    entry_t        tbl_wdata;
    logic          tbl_re;
    entry_t        tbl_rdata;

    logic          req_acc;
    logic [12:0]   hi_clamp;
    logic          overlap;
    logic          s_below;
    logic          e_above;
    logic          last_slot;

    coi_alu u_alu (
        .ctrl (alu_ctrl),
        .y    (alu_y)
    );

    coi_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_acc   = req.valid && req.ready;

    assign wslot_w   = {20'd0, req.entry_index};
    assign rslot_w   = {19'd0, idx_reg};
    assign tbl_waddr = wslot_w[AW-1:0];
    assign tbl_raddr = rslot_w[AW-1:0];
    assign tbl_we    = req_acc && (req.action != ACT_QUERY) && (wslot_w < DEPTH_W);
    assign tbl_wdata = '{start_pos: req.entry_start, end_pos: req.entry_end};
    assign tbl_re    = (state_reg == ST_FETCH);

    assign hi_clamp  = ({19'd0, req.scan_end} > DEPTH_W) ? DEPTH_W[12:0] : req.scan_end;
    assign overlap   = (first_reg < tbl_rdata.end_pos) && (last_reg > tbl_rdata.start_pos);
    assign s_below   = tbl_rdata.start_pos < first_reg;
    assign e_above   = last_reg < tbl_rdata.end_pos;
    assign last_slot = ((idx_reg + 13'd1) == hi_reg);

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.found         = rsp_found_reg;
    assign rsp.best_index    = rsp_idx_reg;
    assign rsp.best_distance = rsp_dist_reg;
    assign rsp.start_offset  = rsp_soff_reg;
    assign rsp.end_offset    = rsp_eoff_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        hi_next        = hi_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        best_ads_next  = best_ads_reg;
        best_sneg_next = best_sneg_reg;
        best_ade_next  = best_ade_reg;
        best_eneg_next = best_eneg_reg;
        ads_next       = ads_reg;
        sneg_next      = sneg_reg;
        ade_next       = ade_reg;
        eneg_next      = eneg_reg;
        dist_next      = dist_reg;
        soff_next      = soff_reg;
        eoff_next      = eoff_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_found_next = rsp_found_reg;
        rsp_idx_next   = rsp_idx_reg;
        rsp_dist_next  = rsp_dist_reg;
        rsp_soff_next  = rsp_soff_reg;
        rsp_eoff_next  = rsp_eoff_reg;
        alu_ctrl       = '{op: ALU_ADD, a: 32'd0, b: 32'd0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && (req.action == ACT_QUERY))
                begin
                    idx_next       = req.scan_begin;
                    hi_next        = hi_clamp;
                    first_next     = req.span_first;
                    last_next      = req.span_last;
                    found_next     = 1'b0;
                    best_idx_next  = 12'd0;
                    best_dist_next = NO_MATCH;
                    state_next     = (req.scan_begin >= hi_clamp) ? ST_NEG_S : ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_ABS_S;
            end
            ST_ABS_S:
            begin
                alu_ctrl.op = ALU_SUB;
                alu_ctrl.a  = s_below ? {1'b0, first_reg} : {1'b0, tbl_rdata.start_pos};
                alu_ctrl.b  = s_below ? {1'b0, tbl_rdata.start_pos} : {1'b0, first_reg};
                ads_next    = alu_y;
                sneg_next   = s_below;
                if (!overlap)
                begin
                    idx_next   = idx_reg + 13'd1;
                    state_next = last_slot ? ST_NEG_S : ST_FETCH;
                end
                else
                begin
                    state_next = ST_ABS_E;
                end
            end
            ST_ABS_E:
            begin
                alu_ctrl.op = ALU_SUB;
                alu_ctrl.a  = e_above ? {1'b0, tbl_rdata.end_pos} : {1'b0, last_reg};
                alu_ctrl.b  = e_above ? {1'b0, last_reg} : {1'b0, tbl_rdata.end_pos};
                ade_next    = alu_y;
                eneg_next   = e_above;
                // early exit: start already lies farther right than the best total
                if (!sneg_reg && (ads_reg > best_dist_reg))
                begin
                    state_next = ST_NEG_S;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                alu_ctrl.op = ALU_ADD;
                alu_ctrl.a  = ads_reg;
                alu_ctrl.b  = ade_reg;
                dist_next   = alu_y;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (dist_reg < best_dist_reg)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = idx_reg[11:0];
                    best_dist_next = dist_reg;
                    best_ads_next  = ads_reg;
                    best_sneg_next = sneg_reg;
                    best_ade_next  = ade_reg;
                    best_eneg_next = eneg_reg;
                end
                idx_next   = idx_reg + 13'd1;
                state_next = last_slot ? ST_NEG_S : ST_FETCH;
            end
            ST_NEG_S:
            begin
                alu_ctrl.op = best_sneg_reg ? ALU_SUB : ALU_ADD;
                alu_ctrl.a  = best_sneg_reg ? 32'd0 : best_ads_reg;
                alu_ctrl.b  = best_sneg_reg ? best_ads_reg : 32'd0;
                soff_next   = found_reg ? alu_y : NO_MATCH;
                state_next  = ST_NEG_E;
            end
            ST_NEG_E:
            begin
                alu_ctrl.op = best_eneg_reg ? ALU_SUB : ALU_ADD;
                alu_ctrl.a  = best_eneg_reg ? 32'd0 : best_ade_reg;
                alu_ctrl.b  = best_eneg_reg ? best_ade_reg : 32'd0;
                eoff_next   = found_reg ? alu_y : NO_MATCH;
                state_next  = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_found_next = found_reg;
                    rsp_idx_next   = best_idx_reg;
                    rsp_dist_next  = best_dist_reg;
                    rsp_soff_next  = soff_reg;
                    rsp_eoff_next  = eoff_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            hi_reg        <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            best_idx_reg  <= '0;
            best_dist_reg <= NO_MATCH;
            best_ads_reg  <= '0;
            best_sneg_reg <= 1'b0;
            best_ade_reg  <= '0;
            best_eneg_reg <= 1'b0;
            ads_reg       <= '0;
            sneg_reg      <= 1'b0;
            ade_reg       <= '0;
            eneg_reg      <= 1'b0;
            dist_reg      <= '0;
            soff_reg      <= '0;
            eoff_reg      <= '0;
            rsp_found_reg <= 1'b0;
            rsp_idx_reg   <= '0;
            rsp_dist_reg  <= '0;
            rsp_soff_reg  <= '0;
            rsp_eoff_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
            hi_reg        <= hi_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            best_idx_reg  <= best_idx_next;
            best_dist_reg <= best_dist_next;
            best_ads_reg  <= best_ads_next;
            best_sneg_reg <= best_sneg_next;
            best_ade_reg  <= best_ade_next;
            best_eneg_reg <= best_eneg_next;
            ads_reg       <= ads_next;
            sneg_reg      <= sneg_next;
            ade_reg       <= ade_next;
            eneg_reg      <= eneg_next;
            dist_reg      <= dist_next;
            soff_reg      <= soff_next;
            eoff_reg      <= eoff_next;
            rsp_found_reg <= rsp_found_next;
            rsp_idx_reg   <= rsp_idx_next;
            rsp_dist_reg  <= rsp_dist_next;
            rsp_soff_reg  <= rsp_soff_next;
            rsp_eoff_reg  <= rsp_eoff_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/coi_checker.sv
// Port-level checks of the interval search, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module coi_checker
    import coi_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        req_action,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic        rsp_found,
    input wire logic [11:0] rsp_best_index,
    input wire logic [31:0] rsp_best_distance
);

    `COI_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_best_distance), "stalled response changed")
    `COI_ASSERT_IMPL(a_nomatch, clk, rst_n, rsp_valid && !rsp_found, (rsp_best_index == 12'd0) && (rsp_best_distance == NO_MATCH), "no-match response malformed")
    `COI_ASSERT_IMPL(a_match_dist, clk, rst_n, rsp_valid && rsp_found, rsp_best_distance < NO_MATCH, "match distance not below limit")
    `COI_ASSERT_NEXT(a_query_busy, clk, rst_n, req_valid && req_ready && (req_action == ACT_QUERY), !req_ready, "ready after query transaction")

endmodule

bind closest_overlap_interval_search_core coi_checker u_coi_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_action        (req.action),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_found         (rsp.found),
    .rsp_best_index    (rsp.best_index),
    .rsp_best_distance (rsp.best_distance)
);

`default_nettype wire

FILE: tb/coi_result_checker.sv
// Scoreboard for the interval search: predicts each query response and checks the rsp channel.
`timescale 1ns / 1ps

module coi_result_checker
    import coi_pkg::*;
#(
    parameter int DEPTH = 4096
)
(
    input  logic clk,
    input  logic rst_n,
    coi_req_if   req,
    coi_rsp_if   rsp,
    output int   errors,
    output int   pending
);

    typedef struct packed {
        logic               found;
        logic        [11:0] index;
        logic        [31:0] distance;
        logic signed [31:0] start_off;
        logic signed [31:0] end_off;
    } hit_t;

    logic [30:0] start_tab [DEPTH];
    logic [30:0] end_tab   [DEPTH];
    hit_t        hit_q     [$];

    function automatic hit_t closest_hit(
        input logic [30:0] first,
        input logic [30:0] last,
        input logic [12:0] lo,
        input logic [12:0] hi
    );
        hit_t        best;
        int unsigned stop;
        logic [11:0] slot;
        longint      so;
        longint      eo;
        longint      span_dist;
        best.found     = 1'b0;
        best.index     = '0;
        best.distance  = NO_MATCH;
        best.start_off = NO_MATCH;
        best.end_off   = NO_MATCH;
        stop = (hi > DEPTH) ? DEPTH : hi;
        for (int unsigned i = lo; i < stop; i++)
        begin
            slot = i[11:0];
            if (!(first < end_tab[slot] && last > start_tab[slot]))
                continue;
            so        = longint'(start_tab[slot]) - longint'(first);
            eo        = longint'(last) - longint'(end_tab[slot]);
            span_dist = ((so < 0) ? -so : so) + ((eo < 0) ? -eo : eo);
            // early exit: interval starts farther past the span than the best so far
            if (so > longint'(best.distance))
                break;
            if (span_dist < longint'(best.distance))
            begin
                best.found     = 1'b1;
                best.index     = slot;
                best.distance  = span_dist[31:0];
                best.start_off = so[31:0];
                best.end_off   = eo[31:0];
            end
        end
        return best;
    endfunction

    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                if (req.action == ACT_QUERY)
                    hit_q.push_back(closest_hit(req.span_first, req.span_last,
                                                req.scan_begin, req.scan_end));
                else if (req.entry_index < DEPTH)
                begin
                    start_tab[req.entry_index] = req.entry_start;
                    end_tab[req.entry_index]   = req.entry_end;
                end
            end
            if (rsp.valid && rsp.ready)
            begin
                if (hit_q.size() == 0)
                begin
                    $error("rsp transaction with no query outstanding");
                    errors++;
                end
                else
                begin
                    want = hit_q.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, rsp.found);
                        errors++;
                    end
                    if (rsp.best_index !== want.index)
                    begin
                        $error("best_index: expected %0d, got %0d",
                               want.index, rsp.best_index);
                        errors++;
                    end
                    if (rsp.best_distance !== want.distance)
                    begin
                        $error("best_distance: expected %0d, got %0d",
                               want.distance, rsp.best_distance);
                        errors++;
                    end
                    if (rsp.start_offset !== want.start_off)
                    begin
                        $error("start_offset: expected %0d, got %0d",
                               want.start_off, rsp.start_offset);
                        errors++;
                    end
                    if (rsp.end_offset !== want.end_off)
                    begin
                        $error("end_offset: expected %0d, got %0d",
                               want.end_off, rsp.end_offset);
                        errors++;
                    end
                end
            end
            pending = hit_q.size();
        end
        else
        begin
            errors  = 0;
            pending = 0;
        end
    end

endmodule

FILE: tb/tb_closest_overlap_interval_search_core.sv
// Top of the interval search testbench: clock, reset, stimulus, rsp back-pressure and verdict.
`timescale 1ns / 1ps

module tb_closest_overlap_interval_search_core;
    import coi_pkg::*;

    localparam int          DEPTH        = 4096;
    localparam int          WINDOW       = 128;
    localparam int          RANDOM_ITEMS = 930;
    localparam int          STALL_LIMIT  = 100000;
    localparam logic        ACT_WRITE    = ~ACT_QUERY;
    localparam logic [30:0] POS_MAX      = 31'h7FFF_FFFF;

    typedef struct packed {
        logic        action;
        logic [11:0] entry_index;
        logic [30:0] entry_start;
        logic [30:0] entry_end;
        logic [12:0] scan_begin;
        logic [12:0] scan_end;
        logic [30:0] span_first;
        logic [30:0] span_last;
    } req_item_t;

    logic        clk;
    logic        rst_n;
    int          errors;
    int          pending;
    bit          filled [DEPTH];
    logic [30:0] locus;

    coi_req_if req();
    coi_rsp_if rsp();

    closest_overlap_interval_search_core #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    coi_result_checker #(
        .DEPTH(DEPTH)
    ) scoreboard (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .errors (errors),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic req_item_t noise_item();
        req_item_t it;
        it.action      = 1'($urandom_range(1));
        it.entry_index = 12'($urandom_range(4095));
        it.entry_start = 31'($urandom_range(POS_MAX));
        it.entry_end   = 31'($urandom_range(POS_MAX));
        it.scan_begin  = 13'($urandom_range(8191));
        it.scan_end    = 13'($urandom_range(8191));
        it.span_first  = 31'($urandom_range(POS_MAX));
        it.span_last   = 31'($urandom_range(POS_MAX));
        return it;
    endfunction

    function automatic req_item_t put_entry(
        input logic [11:0] slot,
        input logic [30:0] s,
        input logic [30:0] e
    );
        req_item_t it;
        it             = noise_item();
        it.action      = ACT_WRITE;
        it.entry_index = slot;
        it.entry_start = s;
        it.entry_end   = e;
        return it;
    endfunction

    function automatic req_item_t find_closest(
        input logic [12:0] lo,
        input logic [12:0] hi,
        input logic [30:0] first,
        input logic [30:0] last
    );
        req_item_t it;
        it            = noise_item();
        it.action     = ACT_QUERY;
        it.scan_begin = lo;
        it.scan_end   = hi;
        it.span_first = first;
        it.span_last  = last;
        return it;
    endfunction

    // Mostly intervals clustered around one locus so spans overlap; some raw noise.
    function automatic req_item_t random_item();
        req_item_t   it;
        int unsigned pick;
        int unsigned cap;
        it   = noise_item();
        pick = $urandom_range(99);
        if ($urandom_range(99) < 45)
        begin
            it.action = ACT_WRITE;
            if (pick < 70)
                it.entry_index = 12'($urandom_range(WINDOW - 1));
            else if (pick < 82)
                it.entry_index = 12'($urandom_range(4095, 4032));
            if ($urandom_range(99) < 88)
            begin
                it.entry_start = 31'(locus + $urandom_range(20000));
                it.entry_end   = 31'(it.entry_start + $urandom_range(3000, 1));
            end
        end
        else
        begin
            it.action = ACT_QUERY;
            if (pick < 8)
            begin
                // empty scan, also with begin past the table
                it.scan_end = 13'($urandom_range(it.scan_begin));
            end
            else
            begin
                it.scan_begin = 13'(($urandom_range(99) < 80) ? $urandom_range(WINDOW - 1)
                                                              : $urandom_range(4095, 4032));
                cap = ($urandom_range(19) == 0) ? 200 : $urandom_range(48, 1);
                it.scan_end = it.scan_begin;
                while (it.scan_end < DEPTH && it.scan_end - it.scan_begin < cap
                       && filled[it.scan_end[11:0]])
                    it.scan_end++;
                if (it.scan_end == DEPTH && $urandom_range(1))
                    it.scan_end = 13'($urandom_range(8191, 4096));
            end
            if ($urandom_range(99) < 85)
            begin
                it.span_first = 31'(locus + $urandom_range(20000));
                it.span_last  = 31'(it.span_first + $urandom_range(4000));
            end
        end
        return it;
    endfunction

    task automatic send(input req_item_t it, input bit may_idle);
        if (may_idle)
            while ($urandom_range(99) < 12)
            begin
                req.valid <= 1'b0;
                @(posedge clk);
            end
        req.valid       <= 1'b1;
        req.action      <= it.action;
        req.entry_index <= it.entry_index;
        req.entry_start <= it.entry_start;
        req.entry_end   <= it.entry_end;
        req.scan_begin  <= it.scan_begin;
        req.scan_end    <= it.scan_end;
        req.span_first  <= it.span_first;
        req.span_last   <= it.span_last;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (it.action != ACT_QUERY)
            filled[it.entry_index] = 1'b1;
    endtask

    // Receiver: random stalls, one long hold-off, and a stretch that never stalls.
    initial
    begin
        int seen;
        int hold_left;
        bit held;
        seen      = 0;
        hold_left = 0;
        held      = 1'b0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
                seen++;
            if (!held && seen == 40)
            begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (seen >= 200 && seen < 320)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(99) >= 12);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        req.valid       <= 1'b0;
        req.action      <= ACT_WRITE;
        req.entry_index <= '0;
        req.entry_start <= '0;
        req.entry_end   <= '0;
        req.scan_begin  <= '0;
        req.scan_end    <= '0;
        req.span_first  <= '0;
        req.span_last   <= '0;
        locus = 31'($urandom_range(32'h7FFF_0000));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(put_entry(12'd0, 31'd100, 31'd200), 1'b1);
        send(put_entry(12'd1, 31'd150, 31'd400), 1'b1);
        send(put_entry(12'd2, 31'd120, 31'd190), 1'b1);
        send(put_entry(12'd3, 31'd100, 31'd200), 1'b1);
        send(find_closest(13'd0, 13'd4, 31'd100, 31'd200), 1'b1);   // exact hit, then early exit
        send(find_closest(13'd0, 13'd4, 31'd130, 31'd390), 1'b1);
        send(find_closest(13'd0, 13'd4, 31'd500, 31'd600), 1'b1);   // no overlap
        send(find_closest(13'd3, 13'd3, 31'd100, 31'd200), 1'b1);   // empty range
        send(find_closest(13'd4096, 13'd8191, 31'd100, 31'd200), 1'b1);
        send(find_closest(13'd8191, 13'd0, 31'd100, 31'd200), 1'b1);
        send(put_entry(12'd4093, 31'd0, 31'd1), 1'b1);
        send(put_entry(12'd4094, POS_MAX - 31'd1, POS_MAX), 1'b1);
        send(put_entry(12'd4095, 31'd0, POS_MAX), 1'b1);
        // huge distance never chosen, then early exit before slot 4095
        send(find_closest(13'd4093, 13'd8191, 31'd0, POS_MAX), 1'b1);
        send(find_closest(13'd4095, 13'd4096, 31'd0, POS_MAX), 1'b1);
        send(find_closest(13'd4094, 13'd4096, POS_MAX - 31'd1, POS_MAX), 1'b1);
        send(put_entry(12'd4, 31'd1000, 31'd2000), 1'b1);
        send(put_entry(12'd5, 31'd5000, 31'd6000), 1'b1);
        send(put_entry(12'd6, 31'd1000, 31'd5500), 1'b1);
        // stops at slot 5, exact slot 6 unseen
        send(find_closest(13'd4, 13'd7, 31'd1000, 31'd5500), 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            send(random_item(), !(n >= 400 && n < 550));
        req.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/coi_pkg.sv
rtl/coi_if.sv
rtl/coi_alu.sv
rtl/coi_table.sv
rtl/closest_overlap_interval_search_core.sv
rtl/coi_checker.sv
tb/coi_result_checker.sv
tb/tb_closest_overlap_interval_search_core.sv
